// ===== rtl/core/i2cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared beat types, command codes and sizing constants.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4,
    OP_NACK  = 3'd5,
    OP_WAIT  = 3'd6
  } op_e;

  localparam logic [2:0] OpLast       = 3'd6;
  localparam logic [7:0] AckLimitInit = 8'd250;
  localparam logic [3:0] BitsPerByte  = 4'd8;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  typedef struct packed {
    logic       command_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_level;
  } in_beat_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
  } out_beat_t;

  typedef struct packed {
    logic       launch;
    op_e        op;
    logic [7:0] wdata;
    logic       sda;
  } cmd_t;

endpackage

// ===== rtl/core/i2cbe_front.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine front end
// Classifies each incoming beat into a tick that may launch a command.
// ----------------------------------------------------------------------------
module i2cbe_front (
  input  i2cbe_pkg::in_beat_t beat_i,
  output i2cbe_pkg::cmd_t     cmd_o
);
  import i2cbe_pkg::*;

  always_comb begin
    cmd_o.launch = beat_i.command_valid && (beat_i.operation <= OpLast);
    cmd_o.op     = op_e'(beat_i.operation);
    cmd_o.wdata  = (beat_i.operation == OP_WRITE) ? beat_i.write_data : 8'd0;
    cmd_o.sda    = beat_i.sda_level;
  end

endmodule

// ===== rtl/core/i2cbe_queue.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine tick queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module i2cbe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  i2cbe_pkg::cmd_t push_data_i,
  output logic            push_stall_o,
  output logic            pop_valid_o,
  output i2cbe_pkg::cmd_t pop_data_o,
  input  logic            pop_ready_i
);
  import i2cbe_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0]   count_q, count_d;
  logic             push, pop;

  assign push_stall_o = (count_q == QCw'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [QAw-1:0] ptr_inc(input logic [QAw-1:0] p);
    ptr_inc = (p == QAw'(QDepth - 1)) ? '0 : p + QAw'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QCw'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/core/i2cbe_back.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine back end
// Phase sequencer for SCL and SDA with a registered result beat.
// ----------------------------------------------------------------------------
module i2cbe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 cmd_valid_i,
  input  i2cbe_pkg::cmd_t      cmd_i,
  output logic                 cmd_ready_o,
  output logic                 out_valid_o,
  output i2cbe_pkg::out_beat_t out_beat_o,
  input  logic                 out_stall_i
);
  import i2cbe_pkg::*;

  op_e        active_q, active_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] bits_q, bits_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] poll_q, poll_d;
  logic       scl_q, scl_d, sda_q, sda_d, en_q, en_d;
  logic       run_q, run_d;
  logic [7:0] limit_q;
  logic       oval_q;
  out_beat_t  obeat_q, obeat_d;
  logic       fire;
  logic       done, ackr;
  logic [7:0] rbyte;
  logic [3:0] bits_inc;
  logic [8:0] poll_inc;

  assign cmd_ready_o = !oval_q || !out_stall_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = oval_q;
  assign out_beat_o  = obeat_q;

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    bits_d   = bits_q;
    shift_d  = shift_q;
    poll_d   = poll_q;
    run_d    = run_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    en_d     = en_q;
    done     = 1'b0;
    ackr     = 1'b0;
    rbyte    = 8'd0;

    if (!run_q && cmd_i.launch) begin
      run_d    = 1'b1;
      active_d = cmd_i.op;
      phase_d  = 2'd0;
      bits_d   = 4'd0;
      poll_d   = 8'd0;
      shift_d  = cmd_i.wdata;
    end

    bits_inc = bits_d + 4'd1;
    poll_inc = {1'b0, poll_d} + 9'd1;

    if (run_d) begin
      case (active_d)
        OP_START: begin
          if (phase_d == 2'd0) begin
            {scl_d, sda_d, en_d} = 3'b111;
            phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            {scl_d, sda_d, en_d} = 3'b101;
            phase_d = 2'd2;
          end else begin
            {scl_d, sda_d, en_d} = 3'b001;
            done = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_d == 2'd0) begin
            {scl_d, sda_d, en_d} = 3'b001;
            phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            {scl_d, sda_d, en_d} = 3'b101;
            phase_d = 2'd2;
          end else if (phase_d == 2'd2) begin
            {scl_d, sda_d, en_d} = 3'b111;
            phase_d = 2'd3;
          end else begin
            {scl_d, sda_d, en_d} = 3'b011;
            done = 1'b1;
          end
        end
        OP_ACK, OP_NACK: begin
          sda_d = (active_d == OP_NACK);
          en_d  = 1'b1;
          if (phase_d == 2'd0) begin
            scl_d   = 1'b0;
            phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            scl_d   = 1'b1;
            phase_d = 2'd2;
          end else begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        end
        OP_WRITE: begin
          en_d = 1'b1;
          if (phase_d == 2'd0) begin
            scl_d   = 1'b0;
            sda_d   = shift_d[7];
            phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            scl_d   = 1'b1;
            sda_d   = shift_d[7];
            shift_d = {shift_d[6:0], 1'b0};
            bits_d  = bits_inc;
            phase_d = (bits_inc >= BitsPerByte) ? 2'd2 : 2'd0;
          end else begin
            scl_d = 1'b0;
            sda_d = sda_q;
            done  = 1'b1;
          end
        end
        OP_READ: begin
          sda_d = 1'b1;
          en_d  = 1'b0;
          if (phase_d == 2'd0) begin
            scl_d   = 1'b0;
            phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            scl_d   = 1'b1;
            shift_d = {shift_d[6:0], cmd_i.sda};
            bits_d  = bits_inc;
            phase_d = (bits_inc >= BitsPerByte) ? 2'd2 : 2'd0;
          end else begin
            scl_d = 1'b0;
            rbyte = shift_d;
            done  = 1'b1;
          end
        end
        OP_WAIT: begin
          sda_d = 1'b1;
          if (phase_d == 2'd0) begin
            scl_d   = 1'b0;
            en_d    = 1'b1;
            phase_d = 2'd1;
          end else if (phase_d == 2'd1) begin
            scl_d   = 1'b1;
            en_d    = 1'b0;
            phase_d = 2'd2;
          end else if (phase_d == 2'd2) begin
            scl_d = 1'b1;
            en_d  = 1'b0;
            if (!cmd_i.sda) begin
              phase_d = 2'd3;
            end else if (poll_inc > {1'b0, limit_q}) begin
              active_d = OP_STOP;
              phase_d  = 2'd0;
            end else begin
              poll_d = poll_inc[7:0];
            end
          end else begin
            scl_d = 1'b0;
            en_d  = 1'b0;
            ackr  = 1'b1;
            done  = 1'b1;
          end
        end
        default: begin
          run_d = 1'b0;
        end
      endcase
      if (done) begin
        run_d = 1'b0;
      end
    end

    obeat_d.scl_level    = scl_d;
    obeat_d.sda_drive    = sda_d;
    obeat_d.sda_enable   = en_d;
    obeat_d.busy_res     = run_d;
    obeat_d.done_res     = done;
    obeat_d.read_byte    = rbyte;
    obeat_d.ack_received = ackr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= OP_START;
      phase_q  <= 2'd0;
      bits_q   <= 4'd0;
      shift_q  <= 8'd0;
      poll_q   <= 8'd0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      en_q     <= 1'b0;
      run_q    <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      if (fire) begin
        active_q <= active_d;
        phase_q  <= phase_d;
        bits_q   <= bits_d;
        shift_q  <= shift_d;
        poll_q   <= poll_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        en_q     <= en_d;
        run_q    <= run_d;
        oval_q   <= 1'b1;
      end else if (!out_stall_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AckLimitInit;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obeat_q <= obeat_d;
    end
  end

endmodule

// ===== rtl/core/i2c_master_byte_engine_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master sequencer with a decoupled classify and execute path.
//
//   Channel   Signals                          Moves
//   input     in_valid_i / in_stall_o          one tick beat, in_beat_i
//   output    out_valid_o / out_stall_i        one result beat per tick
//   config    cfg_we_i / cfg_wdata_i           acknowledge timeout limit
//
// One tick beat is accepted per cycle while in_stall_o is low, and its result
// beat is offered at the output once the tick has passed the queue and the
// result register; the phase sequencer steps once per taken tick.
// Reset leaves SCL high, SDA released and the timeout limit at 250.
// A two-beat queue and the result register absorb output stalls, so the
// input stalls only once both are full.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  i2cbe_pkg::in_beat_t  in_beat_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output i2cbe_pkg::out_beat_t out_beat_o,
  input  logic                 out_stall_i
);
  import i2cbe_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_valid;
  logic back_ready;

  i2cbe_front u_front (
    .beat_i (in_beat_i),
    .cmd_o  (front_cmd)
  );

  i2cbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_data_i  (front_cmd),
    .push_stall_o (in_stall_o),
    .pop_valid_o  (queue_valid),
    .pop_data_o   (queue_cmd),
    .pop_ready_i  (back_ready)
  );

  i2cbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_ready_o (back_ready),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .out_stall_i (out_stall_i)
  );

endmodule
